// ----- hdl/joystick_block_average_direction_unit_assert.svh -----
// Assertion macros for the joystick block averaging unit.
// They expect clk and rst_n to be in scope.
`ifndef JOYSTICK_BLOCK_AVERAGE_DIRECTION_UNIT_ASSERT_SVH
`define JOYSTICK_BLOCK_AVERAGE_DIRECTION_UNIT_ASSERT_SVH

`define JBAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`define JBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/jbad_pkg.sv -----
package jbad_pkg;

  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR  = 2'd2;

  localparam logic [CFG_W-1:0] DEADBAND_RST = 10'd2;
  localparam logic [CFG_W-1:0] LOW_THR_RST  = 10'd500;
  localparam logic [CFG_W-1:0] HIGH_THR_RST = 10'd530;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] deadband;
    logic [CFG_W-1:0] low_thr;
    logic [CFG_W-1:0] high_thr;
  } cfg_t;

  typedef struct packed {
    logic high;
    logic low;
  } lane_flags_t;

endpackage

// ----- hdl/joystick_block_average_direction_unit.sv -----
// Output: the result beat of each accepted input beat is registered in the output buffer.
// Throughput: one beat per cycle; each axis lane accumulates and compares
// combinationally, and a two-entry output buffer holds up to two result
// beats, so in_tready drops only once both are waiting on out_tready.
// Reset: synchronous, active low; clears sums, count, positions and flags and
// loads the deadband and thresholds with 2, 500 and 530.
module joystick_block_average_direction_unit #(
  parameter int LOG2_BLOCK  = 5,
  parameter int SAMPLE_BITS = 10,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 5 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [jbad_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [jbad_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // horiz_sample, vert_sample, zero fill
  input  logic [IN_W-1:0]                 in_tdata,
  // op
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // horiz_position, vert_position, moving_left, moving_right, moving_up,
  // moving_down, block_done, zero fill
  output logic [OUT_W-1:0]                out_tdata
);

  localparam int IDX_W = (LOG2_BLOCK > 0) ? LOG2_BLOCK : 1;
  localparam logic [IDX_W-1:0] BLOCK_LAST = IDX_W'((1 << LOG2_BLOCK) - 1);

  jbad_pkg::cfg_t           cfg_r, cfg_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     in_acc, smp, rd, done;
  logic [SAMPLE_BITS-1:0]   h_pos, v_pos;
  jbad_pkg::lane_flags_t    h_flags, v_flags;
  logic [OUT_W-1:0]         payload;

  assign in_acc = in_tvalid && in_tready;
  assign smp    = in_acc && (in_tuser == jbad_pkg::OP_SAMPLE);
  assign rd     = in_acc && (in_tuser == jbad_pkg::OP_READ);
  assign done   = smp && (idx_r == BLOCK_LAST);

  assign idx_nxt = done ? '0 : (smp ? idx_r + 1'b1 : idx_r);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      case (cfg_addr)
        jbad_pkg::REG_DEADBAND: cfg_nxt.deadband = cfg_wdata;
        jbad_pkg::REG_LOW_THR:  cfg_nxt.low_thr  = cfg_wdata;
        jbad_pkg::REG_HIGH_THR: cfg_nxt.high_thr = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband <= jbad_pkg::DEADBAND_RST;
      cfg_r.low_thr  <= jbad_pkg::LOW_THR_RST;
      cfg_r.high_thr <= jbad_pkg::HIGH_THR_RST;
      idx_r          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      idx_r <= idx_nxt;
    end
  end

  jbad_axis_lane #(
    .LOG2_BLOCK (LOG2_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_horiz (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .acc_en    (smp),
    .blk_end   (done),
    .flag_clr  (rd),
    .pos_view  (h_pos),
    .flags_view(h_flags)
  );

  jbad_axis_lane #(
    .LOG2_BLOCK (LOG2_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_vert (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .sample    (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .acc_en    (smp),
    .blk_end   (done),
    .flag_clr  (rd),
    .pos_view  (v_pos),
    .flags_view(v_flags)
  );

  assign payload = OUT_W'({done, v_flags.low, v_flags.high, h_flags.high, h_flags.low,
                           v_pos, h_pos});

  jbad_out_buf #(
    .W(OUT_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc),
    .push_data(payload),
    .can_push (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

`include "joystick_block_average_direction_unit_assert.svh"

  `JBAD_ASSERT_NOW(a_stall_has_result, !in_tready, out_tvalid)
  `JBAD_ASSERT_NEXT(a_block_wraps, done, idx_r == '0)
  `JBAD_ASSERT_NEXT(a_read_keeps_count, rd, $stable(idx_r))
  `JBAD_ASSERT_NOW(a_read_no_done, rd, !done)

endmodule

// ----- hdl/jbad_axis_lane.sv -----
module jbad_axis_lane #(
  parameter int LOG2_BLOCK  = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jbad_pkg::cfg_t            cfg,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic                      acc_en,
  input  logic                      blk_end,
  input  logic                      flag_clr,
  output logic [SAMPLE_BITS-1:0]    pos_view,
  output jbad_pkg::lane_flags_t     flags_view
);

  localparam int SUM_W = SAMPLE_BITS + LOG2_BLOCK;
  localparam int CMP_W = (SAMPLE_BITS > jbad_pkg::CFG_W) ? SAMPLE_BITS : jbad_pkg::CFG_W;

  logic [SUM_W-1:0]        sum_r, sum_nxt, sum_add;
  logic [SAMPLE_BITS-1:0]  pos_r, pos_nxt, mean, diff;
  jbad_pkg::lane_flags_t   flags_r, flags_nxt;
  logic                    move, at_low, at_high;

  assign sum_add = sum_r + SUM_W'(sample);
  assign mean    = sum_add[SUM_W-1:LOG2_BLOCK];
  assign diff    = (mean > pos_r) ? (mean - pos_r) : (pos_r - mean);
  assign move    = blk_end && (CMP_W'(diff) > CMP_W'(cfg.deadband));
  assign at_low  = CMP_W'(pos_r) <= CMP_W'(cfg.low_thr);
  assign at_high = CMP_W'(pos_r) >= CMP_W'(cfg.high_thr);

  always_comb begin
    flags_view = flags_r;
    if (move && at_low && (mean < pos_r)) begin
      flags_view.low  = 1'b1;
      flags_view.high = 1'b0;
    end else if (move && at_high && (mean > pos_r)) begin
      flags_view.low  = 1'b0;
      flags_view.high = 1'b1;
    end
  end

  assign pos_view  = move ? mean : pos_r;
  assign pos_nxt   = pos_view;
  assign flags_nxt = flag_clr ? '0 : flags_view;
  assign sum_nxt   = blk_end ? '0 : (acc_en ? sum_add : sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      pos_r   <= '0;
      flags_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

// ----- hdl/jbad_out_buf.sv -----
module jbad_out_buf #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         main_vld_r, main_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  logic [W-1:0] main_data_r, main_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;
  logic         main_free;

  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_data_r;
  assign main_free = !main_vld_r || out_ready;

  always_comb begin
    main_vld_nxt  = main_vld_r;
    main_data_nxt = main_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (main_free) begin
      if (skid_vld_r) begin
        main_vld_nxt  = 1'b1;
        main_data_nxt = skid_data_r;
        skid_vld_nxt  = 1'b0;
      end else begin
        main_vld_nxt  = push;
        main_data_nxt = push_data;
      end
    end else if (push) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
